### rtl/mr_pkg.sv
// Package for the Miller-Rabin round block.
// Holds the sequencer phase codes used by the top level.
`timescale 1ns / 1ps
package mr_pkg;
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SPLIT = 3'd1;
	localparam logic [2:0] PH_MUL   = 3'd2;
	localparam logic [2:0] PH_NEXT  = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;
	localparam logic [2:0] PH_SQR   = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;
endpackage

### rtl/mr_modmul.sv
// Bit-serial interleaved shift-add modular multiplier, one multiplier bit a cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module mr_modmul #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] n,
	output logic         done,
	output logic [W-1:0] p
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q, y_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    dbl, dred, sum, sred;
	logic [W-1:0]  a1;

	// acc < n, so 2*acc and acc + x each need at most one subtraction of n.
	always_comb begin
		dbl  = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
		a1   = dred[W-1:0];
		sum  = {1'b0, a1} + {1'b0, x};
		sred = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= y_q[W-1] ? sred[W-1:0] : a1;
			y_q   <= {y_q[W-2:0], 1'b0};
		end
	end

	assign p = acc_q;
endmodule

### rtl/miller_rabin_round.sv
// One Miller-Rabin round on a candidate and a witness.
// Uses mr_pkg for phase codes and mr_modmul as its only arithmetic unit.
//
// Usage: the input channel (in_valid, in_stall) carries one item holding
// candidate n and witness a. The output channel (out_valid, out_stall)
// returns one item per input: probable_prime and bad_input.
// The block works on one item at a time; in_stall is high from acceptance
// until the result has been taken by the receiver.
// Sequence: first n-1 is split into 2^k * q, one bit per cycle. Then
// a^q mod n is formed by square-and-multiply over the bits of q, each
// modular product running in the shared bit-serial multiplier, then up to
// k-1 squarings. The worst case is about 2*NUMBER_BITS products. Bad input
// gives its result in the cycle after acceptance.
// The multiplier, one multiplier bit per cycle, sets the rate.
// Reset clears the sequencer and output valid; no item is in flight after it.
// When the receiver stalls, the result holds on the ports and no new item
// is taken until it leaves.
`timescale 1ns / 1ps
module miller_rabin_round
	import mr_pkg::*;
#(
	parameter int NUMBER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] candidate,
	input  logic [31:0] witness,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        probable_prime,
	output logic        bad_input
);
	localparam int W  = NUMBER_BITS;
	localparam int KW = $clog2(W + 1);

	logic [2:0]    ph_q;
	logic [W-1:0]  n_q, q_q, base_q, res_q, x_q;
	logic [KW-1:0] k_q;
	logic          sqr_base_q;   // in PH_MUL: 1 while squaring the base
	logic [W-1:0]  n_in, a_in;
	logic          mstart, mdone;
	logic [W-1:0]  mx, my, mp;
	logic [63:0]   cand64, wit64;

	// Operands are cut to their low NUMBER_BITS bits.
	assign cand64 = {32'd0, candidate};
	assign wit64  = {32'd0, witness};
	assign n_in   = cand64[W-1:0];
	assign a_in   = wit64[W-1:0];

	assign in_stall = (ph_q != PH_IDLE);

	mr_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .x(mx), .y(my), .n(n_q),
		.done(mdone), .p(mp)
	);

	// In PH_CHECK and PH_SQR, sqr_base_q doubles as "a squaring happened".
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q           <= PH_IDLE;
			out_valid      <= 1'b0;
			mstart         <= 1'b0;
			probable_prime <= 1'b0;
			bad_input      <= 1'b0;
			n_q            <= '0;
			q_q            <= '0;
			k_q            <= '0;
			base_q         <= '0;
			res_q          <= '0;
			x_q            <= '0;
			sqr_base_q     <= 1'b0;
		end else begin
			mstart <= 1'b0;
			unique case (ph_q)
				PH_IDLE: begin
					if (in_valid) begin
						n_q        <= n_in;
						q_q        <= n_in - W'(1);
						k_q        <= '0;
						base_q     <= a_in;
						res_q      <= W'(1);
						sqr_base_q <= 1'b0;
						if (n_in < W'(3) || a_in == '0 || a_in >= n_in) begin
							probable_prime <= 1'b0;
							bad_input      <= 1'b1;
							out_valid      <= 1'b1;
							ph_q           <= PH_DONE;
						end else begin
							bad_input <= 1'b0;
							ph_q      <= PH_SPLIT;
						end
					end
				end
				PH_SPLIT: begin
					// Strip trailing zeros of n-1, one per cycle; an even n has none.
					if (q_q[0] || k_q == '0 && n_q[0] == 1'b0) begin
						ph_q <= PH_NEXT;
					end else begin
						q_q <= q_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
				PH_NEXT: begin
					// Square-and-multiply over the bits of q, lowest first.
					if (q_q == '0) begin
						x_q        <= res_q;
						sqr_base_q <= 1'b0;
						ph_q       <= PH_CHECK;
					end else if (q_q[0]) begin
						sqr_base_q <= 1'b0;
						mstart     <= 1'b1;
						ph_q       <= PH_MUL;
					end else begin
						sqr_base_q <= 1'b1;
						mstart     <= 1'b1;
						ph_q       <= PH_MUL;
					end
				end
				PH_MUL: begin
					if (mdone) begin
						if (!sqr_base_q) begin
							res_q      <= mp;
							sqr_base_q <= 1'b1;
							mstart     <= 1'b1;
						end else begin
							base_q <= mp;
							q_q    <= q_q >> 1;
							ph_q   <= PH_NEXT;
						end
					end
				end
				PH_CHECK: begin
					if (x_q == n_q - W'(1)) begin
						probable_prime <= 1'b1;
						out_valid      <= 1'b1;
						ph_q           <= PH_DONE;
					end else if (x_q == W'(1) || k_q <= KW'(1)) begin
						// x of 1 passes only before any squaring.
						probable_prime <= (x_q == W'(1)) && !sqr_base_q;
						out_valid      <= 1'b1;
						ph_q           <= PH_DONE;
					end else begin
						k_q    <= k_q - 1'b1;
						mstart <= 1'b1;
						ph_q   <= PH_SQR;
					end
				end
				PH_SQR: begin
					if (mdone) begin
						x_q        <= mp;
						sqr_base_q <= 1'b1;
						ph_q       <= PH_CHECK;
					end
				end
				PH_DONE: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						ph_q      <= PH_IDLE;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	// Multiplier operands: result*base, base*base, or x*x. The multiplier
	// samples y at its start and reads x on every cycle, so the selection
	// follows the phase that the product runs in.
	always_comb begin
		if (ph_q == PH_SQR) begin
			mx = x_q;
			my = x_q;
		end else if (ph_q == PH_MUL && !sqr_base_q) begin
			mx = res_q;
			my = base_q;
		end else begin
			mx = base_q;
			my = base_q;
		end
	end
endmodule

### rtl/mr_checker.sv
// Port-level checker for the Miller-Rabin round block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module mr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic probable_prime,
	input logic bad_input
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(probable_prime && bad_input))
		else $error("prime and bad input both set");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(probable_prime) && $stable(bad_input))
		else $error("stalled result changed");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("stall not raised after accept");
endmodule

bind miller_rabin_round mr_checker u_mr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.probable_prime(probable_prime), .bad_input(bad_input)
);
